FILE: sv/sscp_pkg.sv
// Shared constants and types for the segment-pair closest point pipeline.
// No dependencies; used by the interfaces, the divider and the top level.
package sscp_pkg;

  localparam int COORD_BITS  = 16;
  localparam int T_FRAC_BITS = 16;
  localparam int THR_BITS    = 20;
  localparam int DIR_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * DIR_BITS;
  localparam int DOT_BITS    = PROD_BITS + 2;
  localparam int DIV_BITS    = 2 * DOT_BITS;
  localparam int T_BITS      = T_FRAC_BITS + 1;
  localparam int GAP_BITS    = 2 * COORD_BITS + 2;
  localparam int DIV_LAT     = T_FRAC_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIR_BITS-1:0]   dir_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [DOT_BITS-1:0]   dot_t;
  typedef logic signed [DIV_BITS-1:0]   div_t;
  typedef logic [T_BITS-1:0]            t_t;
  typedef logic [THR_BITS-1:0]          thr_t;
  typedef logic [GAP_BITS-1:0]          gap_t;

  localparam t_t T_ONE = t_t'(1) << T_FRAC_BITS;

  // per-item geometry carried down the whole pipe
  typedef struct packed {
    coord_t [2:0] ps;
    coord_t [2:0] qs;
    dir_t   [2:0] dp;
    dir_t   [2:0] dq;
    logic         pt0;
    logic         pt1;
  } geo_t;

  // sideband alongside the first divider bank
  typedef struct packed {
    geo_t g;
    dot_t b;
    dot_t f;
    dot_t e;
    logic dz;
  } mid_t;

  // sideband alongside the second-parameter divider
  typedef struct packed {
    geo_t g;
    t_t   tp1;
    t_t   qb;
    t_t   qc;
    logic neg;
    logic over;
  } late_t;

endpackage

FILE: sv/sscp_if.sv
// Request, response and threshold-write channels for the closest point block.
// Depends on sscp_pkg.
interface seg_in_if;
  logic valid;
  logic ready;
  sscp_pkg::coord_t p_start_x, p_start_y, p_start_z;
  sscp_pkg::coord_t p_end_x, p_end_y, p_end_z;
  sscp_pkg::coord_t q_start_x, q_start_y, q_start_z;
  sscp_pkg::coord_t q_end_x, q_end_y, q_end_z;
  modport source (output valid, p_start_x, p_start_y, p_start_z, p_end_x, p_end_y, p_end_z,
                  q_start_x, q_start_y, q_start_z, q_end_x, q_end_y, q_end_z, input ready);
  modport sink (input valid, p_start_x, p_start_y, p_start_z, p_end_x, p_end_y, p_end_z,
                q_start_x, q_start_y, q_start_z, q_end_x, q_end_y, q_end_z, output ready);
endinterface

interface seg_out_if;
  logic valid;
  logic ready;
  sscp_pkg::t_t     t_first, t_second;
  sscp_pkg::coord_t near_p_x, near_p_y, near_p_z;
  sscp_pkg::coord_t near_q_x, near_q_y, near_q_z;
  sscp_pkg::gap_t   gap_squared;
  modport source (output valid, t_first, t_second, near_p_x, near_p_y, near_p_z,
                  near_q_x, near_q_y, near_q_z, gap_squared, input ready);
  modport sink (input valid, t_first, t_second, near_p_x, near_p_y, near_p_z,
                near_q_x, near_q_y, near_q_z, gap_squared, output ready);
endinterface

interface seg_cfg_if;
  logic valid;
  logic ready;
  sscp_pkg::thr_t degenerate_threshold;
  modport source (output valid, degenerate_threshold, input ready);
  modport sink (input valid, degenerate_threshold, output ready);
endinterface

FILE: sv/sscp_div.sv
// Pipelined clamped fraction divider: clamp(num/den) in Q1.T_FRAC_BITS.
// One quotient bit per stage, after a clamp-check stage. Depends on sscp_pkg.
module sscp_div (
  input  logic             clk,
  input  logic             en,
  input  sscp_pkg::div_t   num,
  input  sscp_pkg::div_t   den,
  output sscp_pkg::t_t     quo
);

  localparam int N = sscp_pkg::T_FRAC_BITS;
  localparam int W = sscp_pkg::DIV_BITS;

  logic [W-1:0]     rem  [0:N];
  logic [W-1:0]     dv   [0:N];
  sscp_pkg::t_t     q    [0:N];
  logic             fix  [0:N];

  // clamp check: non-positive gives 0, num >= den gives 1.0
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= den;
      if (num <= 0) begin
        fix[0] <= 1'b1;
        q[0]   <= '0;
      end else if (num >= den) begin
        fix[0] <= 1'b1;
        q[0]   <= sscp_pkg::T_ONE;
      end else begin
        fix[0] <= 1'b0;
        q[0]   <= '0;
      end
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_bit
    logic [W-1:0] r2;
    logic         ge;
    assign r2 = {rem[k-1][W-2:0], 1'b0};
    assign ge = r2 >= dv[k-1];
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k]  <= dv[k-1];
        fix[k] <= fix[k-1];
        if (fix[k-1]) begin
          rem[k] <= rem[k-1];
          q[k]   <= q[k-1];
        end else begin
          rem[k] <= ge ? r2 - dv[k-1] : r2;
          q[k]   <= {q[k-1][sscp_pkg::T_BITS-2:0], ge};
        end
      end
    end
  end

  assign quo = q[N];

endmodule

FILE: sv/segment_segment_closest_points_top.sv
// Closest points between two 3D segments, Q8.8 in, fixed-point parameters out.
// Depends on sscp_pkg, the channel interfaces and sscp_div.
//
// One segment pair is taken every clock unless the pipe holds, and one result leaves per pair,
// in order. The result path runs through two bit-per-stage divider chains in series: the first
// bank solves the first-segment parameter and its two fallbacks, the second solves the
// second-segment parameter.
// The whole pipe holds when the result is not taken; request ready follows from that.
// The threshold register may be written any time no request is in flight.
module segment_segment_closest_points_top (
  input logic      clk,
  input logic      rst,
  seg_in_if.sink   req,
  seg_out_if.source rsp,
  seg_cfg_if.sink  cfg
);

  localparam int TF     = sscp_pkg::T_FRAC_BITS;
  localparam int LAT    = sscp_pkg::DIV_LAT;
  localparam int NSTAGE = 13 + 2 * LAT;
  localparam int PB     = sscp_pkg::PROD_BITS;
  localparam int DB     = sscp_pkg::DOT_BITS;
  localparam int VB     = sscp_pkg::DIV_BITS;
  localparam int CB     = sscp_pkg::COORD_BITS;

  sscp_pkg::thr_t thr;
  logic [NSTAGE-1:0] vld;
  logic adv;

  assign adv       = !vld[NSTAGE-1] || rsp.ready;
  assign req.ready = adv;
  assign cfg.ready = 1'b1;
  assign rsp.valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
      vld <= '0;
    end else begin
      if (cfg.valid) thr <= cfg.degenerate_threshold;
      if (adv) vld <= {vld[NSTAGE-2:0], req.valid};
    end
  end

  // ---------------- front: differences, products, dot products ----------------
  sscp_pkg::coord_t [2:0] ps_in, pe_in, qs_in, qe_in;
  assign ps_in = {req.p_start_z, req.p_start_y, req.p_start_x};
  assign pe_in = {req.p_end_z, req.p_end_y, req.p_end_x};
  assign qs_in = {req.q_start_z, req.q_start_y, req.q_start_x};
  assign qe_in = {req.q_end_z, req.q_end_y, req.q_end_x};

  sscp_pkg::geo_t g1, g2, g3, g4, g5;
  sscp_pkg::dir_t [2:0] rv1;
  sscp_pkg::prod_t [2:0] paa, pee, pbb, pcc, pff;
  sscp_pkg::dot_t a3, e3, b3, c3, f3, sa, se, sb, sc, sf;
  sscp_pkg::dot_t b4, c4, f4, e4;
  sscp_pkg::div_t ae4, bb4, bf4, ce4;
  sscp_pkg::dot_t b5, f5, e5;
  sscp_pkg::div_t numa5, den5, numb5, numc5, a5;
  logic dz5;

  function automatic sscp_pkg::dot_t dsum(input sscp_pkg::prod_t [2:0] p);
    return DB'($signed(p[0])) + DB'($signed(p[1])) + DB'($signed(p[2]));
  endfunction

  function automatic sscp_pkg::prod_t pmul(input sscp_pkg::dir_t x, input sscp_pkg::dir_t y);
    return PB'($signed(x)) * PB'($signed(y));
  endfunction

  assign sa = dsum(paa);
  assign se = dsum(pee);
  assign sb = dsum(pbb);
  assign sc = dsum(pcc);
  assign sf = dsum(pff);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        g1.ps[i] <= ps_in[i];
        g1.qs[i] <= qs_in[i];
        g1.dp[i] <= sscp_pkg::DIR_BITS'($signed(pe_in[i])) - sscp_pkg::DIR_BITS'($signed(ps_in[i]));
        g1.dq[i] <= sscp_pkg::DIR_BITS'($signed(qe_in[i])) - sscp_pkg::DIR_BITS'($signed(qs_in[i]));
        rv1[i]   <= sscp_pkg::DIR_BITS'($signed(ps_in[i])) - sscp_pkg::DIR_BITS'($signed(qs_in[i]));
      end
      g1.pt0 <= 1'b0;
      g1.pt1 <= 1'b0;

      g2 <= g1;
      for (int i = 0; i < 3; i++) begin
        paa[i] <= pmul(g1.dp[i], g1.dp[i]);
        pee[i] <= pmul(g1.dq[i], g1.dq[i]);
        pbb[i] <= pmul(g1.dp[i], g1.dq[i]);
        pcc[i] <= pmul(g1.dp[i], rv1[i]);
        pff[i] <= pmul(g1.dq[i], rv1[i]);
      end

      g3.ps  <= g2.ps;
      g3.qs  <= g2.qs;
      g3.dp  <= g2.dp;
      g3.dq  <= g2.dq;
      g3.pt0 <= sa <= $signed({{(DB - sscp_pkg::THR_BITS){1'b0}}, thr});
      g3.pt1 <= se <= $signed({{(DB - sscp_pkg::THR_BITS){1'b0}}, thr});
      a3 <= sa;
      e3 <= se;
      b3 <= sb;
      c3 <= sc;
      f3 <= sf;

      g4  <= g3;
      b4  <= b3;
      c4  <= c3;
      f4  <= f3;
      e4  <= e3;
      ae4 <= VB'(a3) * VB'(e3);
      bb4 <= VB'(b3) * VB'(b3);
      bf4 <= VB'(b3) * VB'(f3);
      ce4 <= VB'(c3) * VB'(e3);
      a5  <= VB'(a3);

      g5    <= g4;
      b5    <= b4;
      f5    <= f4;
      e5    <= e4;
      den5  <= ae4 - bb4;
      dz5   <= ae4 == bb4;
      numa5 <= bf4 - ce4;
      numb5 <= -VB'(c4);
      numc5 <= VB'(b4) - VB'(c4);
    end
  end

  // a5 is taken one stage early above; realign it with the other divider inputs
  sscp_pkg::div_t a5d;
  always_ff @(posedge clk) begin
    if (adv) a5d <= a5;
  end

  // ---------------- first divider bank ----------------
  sscp_pkg::t_t qa, qb, qc, qd;

  sscp_div u_div_a (.clk(clk), .en(adv), .num(numa5), .den(den5), .quo(qa));
  sscp_div u_div_b (.clk(clk), .en(adv), .num(numb5), .den(a5d), .quo(qb));
  sscp_div u_div_c (.clk(clk), .en(adv), .num(numc5), .den(a5d), .quo(qc));

  sscp_pkg::mid_t md [0:LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      md[0] <= '{g: g5, b: b5, f: f5, e: e5, dz: dz5};
      for (int k = 1; k < LAT; k++) md[k] <= md[k-1];
    end
  end

  // ---------------- second-segment numerator ----------------
  sscp_pkg::mid_t m1, m2;
  sscp_pkg::t_t tp1_1, qb1, qc1, tp1_2, qb2, qc2;
  sscp_pkg::div_t prod2, num3, den3;
  sscp_pkg::div_t num_c, den_c;
  sscp_pkg::late_t l3;

  assign num_c = prod2 + (VB'(m2.f) <<< TF);
  assign den_c = VB'(m2.e) <<< TF;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1    <= md[LAT-1];
      tp1_1 <= (md[LAT-1].g.pt0 || md[LAT-1].dz) ? '0 : qa;
      qb1   <= qb;
      qc1   <= qc;

      m2    <= m1;
      tp1_2 <= tp1_1;
      qb2   <= qb1;
      qc2   <= qc1;
      prod2 <= VB'(m1.b) * VB'($signed({1'b0, tp1_1}));

      num3 <= num_c;
      den3 <= den_c;
      l3   <= '{g: m2.g, tp1: tp1_2, qb: qb2, qc: qc2,
                neg: num_c < 0, over: den_c < num_c};
    end
  end

  sscp_div u_div_d (.clk(clk), .en(adv), .num(num3), .den(den3), .quo(qd));

  sscp_pkg::late_t ld [0:LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      ld[0] <= l3;
      for (int k = 1; k < LAT; k++) ld[k] <= ld[k-1];
    end
  end

  // ---------------- select parameters, form points and gap ----------------
  sscp_pkg::late_t lq;
  sscp_pkg::t_t tp_s, tq_s;
  sscp_pkg::geo_t gu1, gu2;
  sscp_pkg::t_t tp_u1, tq_u1, tp_u2, tq_u2, tp_u3, tq_u3, tp_u4, tq_u4;
  sscp_pkg::prod_t [2:0] mp, mq;
  sscp_pkg::coord_t [2:0] np3, nq3, np4, nq4;
  sscp_pkg::prod_t [2:0] sq4;
  logic [DB-1:0] gsum;

  assign lq = ld[LAT-1];

  always_comb begin
    tp_s = lq.tp1;
    tq_s = qd;
    if (lq.g.pt0 && lq.g.pt1) begin
      tp_s = '0;
      tq_s = '0;
    end else if (lq.g.pt0) begin
      tp_s = '0;
    end else if (lq.g.pt1) begin
      tp_s = lq.qb;
      tq_s = '0;
    end else if (lq.neg) begin
      tp_s = lq.qb;
      tq_s = '0;
    end else if (lq.over) begin
      tp_s = lq.qc;
      tq_s = sscp_pkg::T_ONE;
    end
  end

  // start + dir*t, product truncated toward zero, saturated to the coordinate range
  function automatic sscp_pkg::coord_t scale_pt(input sscp_pkg::coord_t s,
                                                input sscp_pkg::prod_t p);
    sscp_pkg::prod_t adj;
    logic signed [CB+1:0] v;
    adj = $signed(p) + (p[PB-1] ? $signed(PB'((1 << TF) - 1)) : $signed(PB'(0)));
    v   = (CB+2)'($signed(s)) + (CB+2)'($signed(adj) >>> TF);
    if (v > $signed((CB+2)'((1 << (CB-1)) - 1)))
      return sscp_pkg::coord_t'((1 << (CB-1)) - 1);
    else if (v < -$signed((CB+2)'(1 << (CB-1))))
      return sscp_pkg::coord_t'(1 << (CB-1));
    else
      return sscp_pkg::coord_t'(v);
  endfunction

  assign gsum = DB'(sq4[0]) + DB'(sq4[1]) + DB'(sq4[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      gu1   <= lq.g;
      tp_u1 <= tp_s;
      tq_u1 <= tq_s;

      gu2   <= gu1;
      tp_u2 <= tp_u1;
      tq_u2 <= tq_u1;
      for (int i = 0; i < 3; i++) begin
        mp[i] <= PB'($signed(gu1.dp[i])) * PB'($signed({1'b0, tp_u1}));
        mq[i] <= PB'($signed(gu1.dq[i])) * PB'($signed({1'b0, tq_u1}));
      end

      tp_u3 <= tp_u2;
      tq_u3 <= tq_u2;
      for (int i = 0; i < 3; i++) begin
        np3[i] <= scale_pt(gu2.ps[i], mp[i]);
        nq3[i] <= scale_pt(gu2.qs[i], mq[i]);
      end

      tp_u4 <= tp_u3;
      tq_u4 <= tq_u3;
      np4   <= np3;
      nq4   <= nq3;
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= PB'(sscp_pkg::DIR_BITS'($signed(np3[i])) - sscp_pkg::DIR_BITS'($signed(nq3[i])))
                * PB'(sscp_pkg::DIR_BITS'($signed(np3[i])) - sscp_pkg::DIR_BITS'($signed(nq3[i])));
      end

      rsp.t_first  <= tp_u4;
      rsp.t_second <= tq_u4;
      rsp.near_p_x <= np4[0];
      rsp.near_p_y <= np4[1];
      rsp.near_p_z <= np4[2];
      rsp.near_q_x <= nq4[0];
      rsp.near_q_y <= nq4[1];
      rsp.near_q_z <= nq4[2];
      rsp.gap_squared <= (gsum[DB-1:sscp_pkg::GAP_BITS] != '0) ? '1
                         : gsum[sscp_pkg::GAP_BITS-1:0];
    end
  end

endmodule

FILE: tb/tb_segment_segment_closest_points_top.sv
// Testbench for segment_segment_closest_points_top: random and directed segment pairs,
// threshold phases, random stalls on both sides, in-order scoreboard.
// Depends on sscp_pkg, sscp_if.sv and the RTL top level.
module tb_segment_segment_closest_points_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] big_t;

  typedef struct {
    sscp_pkg::coord_t ps[3];
    sscp_pkg::coord_t pe[3];
    sscp_pkg::coord_t qs[3];
    sscp_pkg::coord_t qe[3];
  } seg_pair_t;

  typedef struct {
    sscp_pkg::t_t     tp;
    sscp_pkg::t_t     tq;
    sscp_pkg::coord_t np[3];
    sscp_pkg::coord_t nq[3];
    sscp_pkg::gap_t   gap;
  } closest_t;

  class closest_scoreboard;
    sscp_pkg::thr_t thresh;
    closest_t       pending[$];
    int             errors;

    function new();
      thresh = '0;
      errors = 0;
    endfunction

    function void report(string what, longint got, longint want);
      $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endfunction

    // clamp(n / d) in Q1.16, d positive
    function sscp_pkg::t_t frac_clamp(big_t n, big_t d);
      big_t q;
      if (n <= 0) return '0;
      if (n >= d) return sscp_pkg::T_ONE;
      q = (n <<< sscp_pkg::T_FRAC_BITS) / d;
      return sscp_pkg::t_t'(q);
    endfunction

    function sscp_pkg::coord_t scale(sscp_pkg::coord_t start, big_t dir, sscp_pkg::t_t t);
      longint prod, v;
      prod = longint'(dir) * longint'({1'b0, t});
      v = longint'(start) + prod / (longint'(1) << sscp_pkg::T_FRAC_BITS);
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return sscp_pkg::coord_t'(v);
    endfunction

    function void note_request(seg_pair_t s);
      big_t dp[3], dq[3], rv[3];
      big_t a, e, b, c, f, den, num, thr, gsum, d;
      bit pt0, pt1;
      closest_t r;
      a = 0; e = 0; b = 0; c = 0; f = 0; gsum = 0;
      for (int i = 0; i < 3; i++) begin
        dp[i] = big_t'(s.pe[i]) - big_t'(s.ps[i]);
        dq[i] = big_t'(s.qe[i]) - big_t'(s.qs[i]);
        rv[i] = big_t'(s.ps[i]) - big_t'(s.qs[i]);
        a += dp[i] * dp[i];
        e += dq[i] * dq[i];
        b += dp[i] * dq[i];
        c += dp[i] * rv[i];
        f += dq[i] * rv[i];
      end
      thr = big_t'({1'b0, thresh});
      pt0 = a <= thr;
      pt1 = e <= thr;
      if (pt0 && pt1) begin
        r.tp = '0; r.tq = '0;
      end else if (pt0) begin
        r.tp = '0; r.tq = frac_clamp(f, e);
      end else if (pt1) begin
        r.tq = '0; r.tp = frac_clamp(-c, a);
      end else begin
        den = a * e - b * b;
        r.tp = (den != 0) ? frac_clamp(b * f - c * e, den) : sscp_pkg::t_t'(0);
        num = b * big_t'({1'b0, r.tp}) + (f <<< sscp_pkg::T_FRAC_BITS);
        den = e <<< sscp_pkg::T_FRAC_BITS;
        if (num < 0) begin
          r.tq = '0; r.tp = frac_clamp(-c, a);
        end else if (num > den) begin
          r.tq = sscp_pkg::T_ONE; r.tp = frac_clamp(b - c, a);
        end else begin
          r.tq = frac_clamp(num, den);
        end
      end
      for (int i = 0; i < 3; i++) begin
        r.np[i] = scale(s.ps[i], dp[i], r.tp);
        r.nq[i] = scale(s.qs[i], dq[i], r.tq);
        d = big_t'(r.np[i]) - big_t'(r.nq[i]);
        gsum += d * d;
      end
      r.gap = (gsum > big_t'({sscp_pkg::GAP_BITS{1'b1}})) ? {sscp_pkg::GAP_BITS{1'b1}}
                                                           : sscp_pkg::gap_t'(gsum);
      pending.push_back(r);
    endfunction

    function void check_result(closest_t got);
      closest_t w;
      if (pending.size() == 0) begin
        report("result with no request outstanding", 0, 0);
        return;
      end
      w = pending.pop_front();
      if (got.tp !== w.tp) report("t_first", got.tp, w.tp);
      if (got.tq !== w.tq) report("t_second", got.tq, w.tq);
      for (int i = 0; i < 3; i++) begin
        if (got.np[i] !== w.np[i]) report($sformatf("near_p[%0d]", i), got.np[i], w.np[i]);
        if (got.nq[i] !== w.nq[i]) report($sformatf("near_q[%0d]", i), got.nq[i], w.nq[i]);
      end
      if (got.gap !== w.gap) report("gap_squared", got.gap, w.gap);
    endfunction
  endclass

  logic clk;
  logic rst;
  seg_in_if  req();
  seg_out_if rsp();
  seg_cfg_if cfg();

  segment_segment_closest_points_top dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  closest_scoreboard sb = new();
  bit no_idle;
  bit drain;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("segment_segment_closest_points_top: mismatch");
    $finish;
  end

  // monitor: all sampling at the clock edge
  always @(posedge clk) begin
    closest_t got;
    seg_pair_t s;
    if (!rst) begin
      if (cfg.valid && cfg.ready) sb.thresh = cfg.degenerate_threshold;
      if (req.valid && req.ready) begin
        s.ps = '{req.p_start_x, req.p_start_y, req.p_start_z};
        s.pe = '{req.p_end_x, req.p_end_y, req.p_end_z};
        s.qs = '{req.q_start_x, req.q_start_y, req.q_start_z};
        s.qe = '{req.q_end_x, req.q_end_y, req.q_end_z};
        sb.note_request(s);
      end
      if (rsp.valid && rsp.ready) begin
        got.tp = rsp.t_first;
        got.tq = rsp.t_second;
        got.np = '{rsp.near_p_x, rsp.near_p_y, rsp.near_p_z};
        got.nq = '{rsp.near_q_x, rsp.near_q_y, rsp.near_q_z};
        got.gap = rsp.gap_squared;
        sb.check_result(got);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // result-side stalls
  initial begin
    int g;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      rsp.ready <= 1'b1;
      @(posedge clk);
      g = drain ? 0 : pick_gap();
      if (g > 0) begin
        rsp.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  task automatic send_pair(seg_pair_t s);
    int g;
    req.valid <= 1'b1;
    req.p_start_x <= s.ps[0]; req.p_start_y <= s.ps[1]; req.p_start_z <= s.ps[2];
    req.p_end_x <= s.pe[0]; req.p_end_y <= s.pe[1]; req.p_end_z <= s.pe[2];
    req.q_start_x <= s.qs[0]; req.q_start_y <= s.qs[1]; req.q_start_z <= s.qs[2];
    req.q_end_x <= s.qe[0]; req.q_end_y <= s.qe[1]; req.q_end_z <= s.qe[2];
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    g = pick_gap();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_threshold(sscp_pkg::thr_t v);
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.degenerate_threshold <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic seg_pair_t make_pair(sscp_pkg::coord_t p0[3], sscp_pkg::coord_t p1[3],
                                          sscp_pkg::coord_t q0[3], sscp_pkg::coord_t q1[3]);
    seg_pair_t s;
    s.ps = p0; s.pe = p1; s.qs = q0; s.qe = q1;
    return s;
  endfunction

  function automatic sscp_pkg::coord_t corner_coord();
    case ($urandom_range(0, 3))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      default: return sscp_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t s;
    int mode, k;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0, 1: begin
          s.ps[i] = sscp_pkg::coord_t'($urandom); s.pe[i] = sscp_pkg::coord_t'($urandom);
          s.qs[i] = sscp_pkg::coord_t'($urandom); s.qe[i] = sscp_pkg::coord_t'($urandom);
        end
        2: begin // short first segment
          s.ps[i] = sscp_pkg::coord_t'($urandom_range(0, 60000) - 30000);
          s.pe[i] = s.ps[i] + sscp_pkg::coord_t'($urandom_range(0, 8) - 4);
          s.qs[i] = sscp_pkg::coord_t'($urandom); s.qe[i] = sscp_pkg::coord_t'($urandom);
        end
        3: begin // short second segment
          s.ps[i] = sscp_pkg::coord_t'($urandom); s.pe[i] = sscp_pkg::coord_t'($urandom);
          s.qs[i] = sscp_pkg::coord_t'($urandom_range(0, 60000) - 30000);
          s.qe[i] = s.qs[i] + sscp_pkg::coord_t'($urandom_range(0, 8) - 4);
        end
        4, 5: begin // parallel or collinear
          s.ps[i] = sscp_pkg::coord_t'($urandom_range(0, 16000) - 8000);
          s.pe[i] = s.ps[i] + sscp_pkg::coord_t'($urandom_range(0, 8000) - 4000);
          s.qs[i] = (mode == 5) ? s.ps[i]
                                : sscp_pkg::coord_t'($urandom_range(0, 16000) - 8000);
        end
        6: begin
          s.ps[i] = corner_coord(); s.pe[i] = corner_coord();
          s.qs[i] = corner_coord(); s.qe[i] = corner_coord();
        end
        default: begin
          s.ps[i] = sscp_pkg::coord_t'($urandom_range(0, 4000) - 2000);
          s.pe[i] = sscp_pkg::coord_t'($urandom_range(0, 4000) - 2000);
          s.qs[i] = sscp_pkg::coord_t'($urandom_range(0, 4000) - 2000);
          s.qe[i] = sscp_pkg::coord_t'($urandom_range(0, 4000) - 2000);
        end
      endcase
    end
    if (mode == 4 || mode == 5) begin
      k = $urandom_range(0, 4) - 2;
      if (mode == 5 && k == 0) k = 1;
      for (int i = 0; i < 3; i++)
        s.qe[i] = s.qs[i] + sscp_pkg::coord_t'(k * (s.pe[i] - s.ps[i]));
    end
    return s;
  endfunction

  task automatic run_directed();
    sscp_pkg::coord_t z[3], mn[3], mx[3], u[3], v[3], w[3], h[3];
    z = '{0, 0, 0};
    mn = '{-32768, -32768, -32768};
    mx = '{32767, 32767, 32767};
    u = '{256, 0, 0};
    v = '{0, 256, 0};
    w = '{512, 0, 0};
    h = '{-256, 0, 0};
    send_pair(make_pair(z, z, z, z));                              // both points
    send_pair(make_pair(mn, mn, mx, mx));                          // both points, far apart
    send_pair(make_pair(mn, mx, mx, mn));                          // one diagonal, both directions
    send_pair(make_pair(mx, mn, mn, mx));
    send_pair(make_pair(mn, mx, '{-32768, 32767, -32768}, '{32767, -32768, 32767}));
    send_pair(make_pair(u, u, z, w));                              // first is a point
    send_pair(make_pair(z, w, v, v));                              // second is a point
    send_pair(make_pair(z, w, v, '{512, 256, 0}));                 // parallel
    send_pair(make_pair(z, w, u, '{768, 0, 0}));                   // collinear overlap
    send_pair(make_pair(h, u, '{0, -256, 256}, '{0, 256, 256}));   // perpendicular cross
    send_pair(make_pair(z, u, '{512, 256, 0}, '{512, 512, 0}));    // second param below 0
    send_pair(make_pair(z, u, '{512, -512, 0}, '{512, -256, 0}));  // second param above 1
    send_pair(make_pair(z, w, '{-512, 256, 0}, '{-256, 256, 0}));  // beyond start
    send_pair(make_pair(z, w, '{1024, 256, 0}, '{1280, 512, 0}));  // beyond end
    send_pair(make_pair(z, '{1, 0, 0}, z, '{0, 1, 0}));            // tiny segments
    send_pair(make_pair(mn, mx, z, z));
    send_pair(make_pair(z, z, mn, mx));
    send_pair(make_pair(mx, mx, mn, mx));
  endtask

  initial begin
    sscp_pkg::thr_t phases[5];
    phases = '{sscp_pkg::thr_t'(0), {sscp_pkg::THR_BITS{1'b1}}, sscp_pkg::thr_t'(65536),
               sscp_pkg::thr_t'($urandom), sscp_pkg::thr_t'(1)};
    rst = 1'b1;
    no_idle = 1'b0;
    drain = 1'b0;
    req.valid <= 1'b0;
    req.p_start_x <= '0; req.p_start_y <= '0; req.p_start_z <= '0;
    req.p_end_x <= '0; req.p_end_y <= '0; req.p_end_z <= '0;
    req.q_start_x <= '0; req.q_start_y <= '0; req.q_start_z <= '0;
    req.q_end_x <= '0; req.q_end_y <= '0; req.q_end_z <= '0;
    cfg.valid <= 1'b0;
    cfg.degenerate_threshold <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < 5; p++) begin
      write_threshold(phases[p]);
      if (p == 1) run_directed();
      for (int n = 0; n < 290; n++) begin
        // a burst with no idling now and then
        if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_pair(random_pair());
      end
    end
    req.valid <= 1'b0;
    drain = 1'b1;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("segment_segment_closest_points_top: match");
    end else begin
      $display("segment_segment_closest_points_top: mismatch");
    end
    $finish;
  end
endmodule
